// ===== rtl/core/lruc_pkg.sv =====
// Shared types and request codes for the LRU verdict cache.
package lruc_pkg;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_GET    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] device_id;
    logic [63:0] inode_number;
    logic signed [63:0] mod_time;
    logic [7:0]  verdict_in;
  } in_word_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] verdict_out;
    logic [6:0] occupancy;
  } out_word_t;

  // One stored entry.
  typedef struct packed {
    logic [31:0] dev;
    logic [63:0] ino;
    logic [63:0] mtime;
    logic [7:0]  verdict;
  } entry_t;

  // Control broadcast to every cell in the update cycle.
  typedef struct packed {
    logic   upd;      // apply an update this cycle
    logic   clear;    // drop all entries
    logic   ins;      // insert head entry at slot 0
    logic   del;      // delete the matched slot
    logic   mtf;      // move matched slot to front
    logic   trunc;    // drop slots at or above keep
    entry_t head;     // entry written at slot 0
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

endpackage

// ===== rtl/core/lruc_cell.sv =====
// One cache slot: holds an entry and compares it against the request key.
module lruc_cell #(
  parameter int IDXW = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [IDXW-1:0]     pos,
  input  logic [31:0]         key_dev,
  input  logic [63:0]         key_ino,
  input  lruc_pkg::cell_ctl_t ctl,
  input  logic [IDXW:0]       match_pos,
  input  logic                match_any,
  input  logic [IDXW:0]       keep,
  input  lruc_pkg::entry_t    prev_entry,
  input  logic                prev_valid,
  input  lruc_pkg::entry_t    next_entry,
  input  logic                next_valid,
  output lruc_pkg::entry_t    entry,
  output logic                valid,
  output logic                match
);

  lruc_pkg::entry_t entry_r, entry_nxt;
  logic             valid_r, valid_nxt;
  logic [IDXW:0]    p;

  assign p     = {1'b0, pos};
  assign entry = entry_r;
  assign valid = valid_r;
  assign match = valid_r && entry_r.dev == key_dev && entry_r.ino == key_ino;

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctl.upd) begin
      if (ctl.clear) begin
        valid_nxt = 1'b0;
      end else begin
        // Delete: slots at and past the hole pull from the right.
        if (ctl.del && match_any && p >= match_pos) begin
          entry_nxt = next_entry;
          valid_nxt = next_valid;
        end
        // Move to front: slots up to the hole pull from the left.
        if (ctl.mtf && match_any && p <= match_pos) begin
          if (p == '0) begin
            entry_nxt = ctl.head;
          end else begin
            entry_nxt = prev_entry;
          end
        end
        // Insert: slots up to any deleted hole pull from the left.
        if (ctl.ins) begin
          if (p == '0) begin
            entry_nxt = ctl.head;
            valid_nxt = 1'b1;
          end else if (ctl.del && match_any && p > match_pos) begin
            entry_nxt = entry_r;
            valid_nxt = valid_r;
          end else if (ctl.del && match_any) begin
            entry_nxt = prev_entry;
            valid_nxt = prev_valid;
          end else begin
            entry_nxt = prev_entry;
            valid_nxt = prev_valid && (p <= keep);
          end
        end else if (ctl.trunc && p >= keep) begin
          valid_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    entry_r <= entry_nxt;
  end

endmodule

// ===== rtl/core/lru_validated_result_cache.sv =====
// Top level of the LRU verdict cache: control sequencer and the row of slot cells.
//
//   channel | ports                           | handshake
//   input   | start, busy, in_word            | taken when start && !busy
//   result  | out_valid, out_word             | one-cycle strobe, no stall
//   config  | cfg_we, cfg_max_entries         | written when cfg_we
//
// Each request passes a compare state in which every cell matches the key in
// parallel and a priority pick finds the first hit, then an update state in
// which each cell loads from itself, a neighbor or the head entry. The word is
// out on the cycle after the update. busy is high in the compare and update
// states, so the next word can be taken at the edge that ends the result cycle.
// Reset (rst_n low, synchronous) empties the cache and sets the limit to 64.
// The receiver cannot stall; a word is shown once.
module lru_validated_result_cache #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lruc_pkg::in_word_t  in_word,
  output logic                out_valid,
  output lruc_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_max_entries
);

  localparam int IDXW = $clog2(CAPACITY);

  lruc_pkg::state_t    state_r, state_nxt;
  lruc_pkg::in_word_t  req_r;
  logic [6:0]          max_r;
  logic [IDXW:0]       count_r, count_nxt;
  logic                out_valid_r;
  lruc_pkg::out_word_t out_r;

  // Compare-cycle results, registered for the update cycle.
  logic [IDXW:0]       mpos_r;
  logic                many_r;
  lruc_pkg::entry_t    ment_r;

  lruc_pkg::entry_t    ents  [CAPACITY];
  logic [CAPACITY-1:0] vals;
  logic [CAPACITY-1:0] mat;
  lruc_pkg::cell_ctl_t ctl;

  logic [IDXW:0]       limit;
  logic [IDXW:0]       keep;
  logic                lim_zero;
  logic [IDXW:0]       mpos;
  logic                many;
  lruc_pkg::entry_t    ment;
  logic                stale;
  logic                fire;

  assign fire = start && !busy;
  assign busy = state_r != lruc_pkg::ST_IDLE;

  // Limit clamped to capacity.
  always_comb begin
    if ({25'd0, max_r} > CAPACITY) limit = (IDXW+1)'(CAPACITY);
    else limit = (IDXW+1)'(max_r);
  end
  assign lim_zero = max_r == 7'd0;

  // First matching slot; only valid slots can match, valid slots are packed.
  always_comb begin
    mpos = '0;
    many = 1'b0;
    ment = ents[0];
    for (int i = CAPACITY-1; i >= 0; i--) begin
      if (mat[i]) begin
        mpos = (IDXW+1)'(i);
        many = 1'b1;
        ment = ents[i];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lruc_pkg::ST_IDLE: if (fire) state_nxt = lruc_pkg::ST_CMP;
      lruc_pkg::ST_CMP:  state_nxt = lruc_pkg::ST_UPD;
      lruc_pkg::ST_UPD:  state_nxt = lruc_pkg::ST_IDLE;
      default:           state_nxt = lruc_pkg::ST_IDLE;
    endcase
  end

  assign stale = many_r && ment_r.mtime != req_r.mod_time;

  // Update-cycle control and new count.
  always_comb begin
    ctl       = '0;
    ctl.upd   = state_r == lruc_pkg::ST_UPD;
    ctl.head  = ment_r;
    keep      = count_r;
    count_nxt = count_r;
    case (lruc_pkg::req_t'(req_r.req_type))
      lruc_pkg::REQ_ADD: begin
        if (!lim_zero) begin
          ctl.ins  = 1'b1;
          ctl.head = '{dev: req_r.device_id, ino: req_r.inode_number,
                       mtime: req_r.mod_time, verdict: req_r.verdict_in};
          if (many_r) begin
            ctl.del   = 1'b1;
          end else begin
            // When full, keep limit-1 old entries, shifted up by one.
            if (count_r >= limit) keep = limit - 1'b1;
            count_nxt = keep + 1'b1;
          end
        end
      end
      lruc_pkg::REQ_GET: begin
        if (many_r) begin
          if (stale) begin
            ctl.del   = 1'b1;
            count_nxt = count_r - 1'b1;
          end else begin
            ctl.mtf   = 1'b1;
          end
        end
      end
      lruc_pkg::REQ_REMOVE: begin
        if (many_r) begin
          ctl.del   = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      lruc_pkg::REQ_CLEAR: begin
        ctl.clear = 1'b1;
        count_nxt = '0;
      end
      default: ;
    endcase
    if (!ctl.upd) count_nxt = count_r;
  end

  // keep for insert is the number of old entries that survive; the cell at p
  // pulls old index p-1, so p <= keep means old index < keep survives.
  logic [IDXW:0] keep_cell;
  assign keep_cell = keep;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      lruc_pkg::entry_t pe, ne;
      logic             pv, nv;
      if (g == 0) begin : g_first
        assign pe = ents[0];
        assign pv = 1'b0;
      end else begin : g_mid
        assign pe = ents[g-1];
        assign pv = vals[g-1];
      end
      if (g == CAPACITY-1) begin : g_last
        assign ne = ents[g];
        assign nv = 1'b0;
      end else begin : g_inner
        assign ne = ents[g+1];
        assign nv = vals[g+1];
      end
      lruc_cell #(.IDXW(IDXW)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .pos        (IDXW'(g)),
        .key_dev    (req_r.device_id),
        .key_ino    (req_r.inode_number),
        .ctl        (ctl),
        .match_pos  (mpos_r),
        .match_any  (many_r),
        .keep       (keep_cell),
        .prev_entry (pe),
        .prev_valid (pv),
        .next_entry (ne),
        .next_valid (nv),
        .entry      (ents[g]),
        .valid      (vals[g]),
        .match      (mat[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lruc_pkg::ST_IDLE;
      max_r       <= 7'd64;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= ctl.upd;
      if (cfg_we) max_r <= cfg_max_entries;
    end
    if (fire) req_r <= in_word;
    // Compare cycle: cells see the registered key; hold the first hit.
    if (state_r == lruc_pkg::ST_CMP) begin
      mpos_r <= mpos;
      many_r <= many;
      ment_r <= ment;
    end
    if (ctl.upd) begin
      out_r.hit         <= req_r.req_type == lruc_pkg::REQ_GET && many_r && !stale;
      out_r.verdict_out <= (req_r.req_type == lruc_pkg::REQ_GET && many_r && !stale)
                           ? ment_r.verdict : 8'd0;
      out_r.occupancy   <= 7'(count_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  property p_busy_after_start;
    @(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy;
  endproperty
  a_busy_after_start: assert property (p_busy_after_start) else $error("busy not set");

  property p_out_after_upd;
    @(posedge clk) disable iff (!rst_n) (state_r == lruc_pkg::ST_UPD) |=> out_valid;
  endproperty
  a_out_after_upd: assert property (p_out_after_upd) else $error("missing result");

  property p_count_bound;
    @(posedge clk) disable iff (!rst_n) count_r <= (IDXW+1)'(CAPACITY);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("count overflow");

endmodule
